>>> rtl/core/grid_bucket_counting_sort_assert.svh
// Assertion macros shared by the grid bucket counting sort RTL.
`ifndef GRID_BUCKET_COUNTING_SORT_ASSERT_SVH
`define GRID_BUCKET_COUNTING_SORT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GBCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GBCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/gbcs_pkg.sv
// Types and constants of the grid bucket counting sort.
package gbcs_pkg;

  localparam int MAX_POINTS  = 4096;
  localparam int MAX_BUCKETS = 4096;
  localparam int PIDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W       = PIDX_W + 1;
  localparam int BKT_W       = $clog2(MAX_BUCKETS);
  localparam int BS_DEPTH    = MAX_BUCKETS + 1;
  localparam int BS_AW       = $clog2(BS_DEPTH);
  localparam int VAL_W       = 13;
  localparam int COORD_W     = 24;
  localparam int DIM_W       = 7;
  localparam int SHIFT_W     = 5;
  localparam int CFG_IDX_W   = 3;

  localparam logic [1:0] REQ_ADD        = 2'd0;
  localparam logic [1:0] REQ_READ_ENTRY = 2'd1;
  localparam logic [1:0] REQ_READ_START = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_SHIFT = 3'd4;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
    logic [VAL_W-1:0]          read_slot;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] result_value;
    logic [1:0]       status;
  } out_t;

endpackage

>>> rtl/core/grid_bucket_counting_sort.sv
// Grid bucket counting sort: bucket assignment, rebuild sequencer and read-back.
// An add or out-of-range read gives its result from S_EXEC, a memory read from S_RD after it.
// A point carrying last_point then runs a rebuild of clear, count, prefix-sum and scatter
// passes for n points and nb buckets, made of read-modify-writes over simple dual-port RAMs.
// One item at a time: the next is accepted once the result is taken and any rebuild is done.
// Synchronous active-low reset clears control state and most registers, not the RAM contents.
`include "grid_bucket_counting_sort_assert.svh"

module grid_bucket_counting_sort
  import gbcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_CLR   = 4'd3;
  localparam logic [3:0] S_CNT_A = 4'd4;
  localparam logic [3:0] S_CNT_B = 4'd5;
  localparam logic [3:0] S_CNT_C = 4'd6;
  localparam logic [3:0] S_PFX_A = 4'd7;
  localparam logic [3:0] S_PFX_B = 4'd8;
  localparam logic [3:0] S_SC_A  = 4'd9;
  localparam logic [3:0] S_SC_B  = 4'd10;
  localparam logic [3:0] S_SC_C  = 4'd11;

  logic [3:0]                state_r;
  logic signed [COORD_W-1:0] origin_x_r, origin_y_r;
  logic [DIM_W-1:0]          grid_width_r, grid_height_r;
  logic [SHIFT_W-1:0]        bucket_shift_r;
  in_t                       req_r;
  logic [CNT_W-1:0]          count_r;
  logic                      closed_r;
  logic                      built_r;
  logic [CNT_W-1:0]          built_buckets_r;
  logic [CNT_W-1:0]          idx_r;
  logic [CNT_W-1:0]          acc_r;
  logic [BKT_W-1:0]          bkt_r;
  logic                      out_valid_r;
  out_t                      out_data_r;

  logic                      pb_we, bs_we, fp_we, se_we;
  logic [PIDX_W-1:0]         pb_waddr, pb_raddr, se_waddr, se_raddr;
  logic [BKT_W-1:0]          pb_wdata, pb_rdata, fp_waddr, fp_raddr;
  logic [BS_AW-1:0]          bs_waddr, bs_raddr;
  logic [CNT_W-1:0]          bs_wdata, bs_rdata, fp_wdata, fp_rdata;
  logic [PIDX_W-1:0]         se_wdata, se_rdata;

  logic [DIM_W-1:0]          w_eff, h_eff;
  logic [CNT_W-1:0]          nb;
  logic [BKT_W-1:0]          new_bucket;
  logic [BKT_W-1:0]          sat_b;
  logic [CNT_W-1:0]          add_base;
  logic [CNT_W-1:0]          pfx_sum;
  logic                      in_acc;

  function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(64)) begin
      r = DIM_W'(64);
    end else begin
      r = d;
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] along_axis(input logic signed [COORD_W-1:0] c,
                                                   input logic signed [COORD_W-1:0] o,
                                                   input logic [DIM_W-1:0] cnt,
                                                   input logic [SHIFT_W-1:0] sh);
    logic signed [COORD_W:0] off;
    logic [COORD_W-1:0]      q;
    logic [DIM_W-1:0]        r;
    off = {c[COORD_W-1], c} - {o[COORD_W-1], o};
    q   = off[COORD_W-1:0] >> sh;
    if (off[COORD_W] || off == '0) begin
      r = '0;
    end else if (q >= COORD_W'(cnt - DIM_W'(1))) begin
      r = cnt - DIM_W'(1);
    end else begin
      r = q[DIM_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    logic [DIM_W-1:0] col, row;
    logic [CNT_W-1:0] lin;
    w_eff      = dim_of(grid_width_r);
    h_eff      = dim_of(grid_height_r);
    nb         = CNT_W'(w_eff) * CNT_W'(h_eff);
    col        = along_axis(req_r.point_x, origin_x_r, w_eff, bucket_shift_r);
    row        = along_axis(req_r.point_y, origin_y_r, h_eff, bucket_shift_r);
    lin        = CNT_W'(row) * CNT_W'(w_eff) + CNT_W'(col);
    new_bucket = lin[BKT_W-1:0];
    sat_b      = ({1'b0, pb_rdata} >= nb) ? BKT_W'(nb - CNT_W'(1)) : pb_rdata;
    add_base   = closed_r ? '0 : count_r;
    pfx_sum    = acc_r + bs_rdata;
  end

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    pb_we = 1'b0; pb_waddr = idx_r[PIDX_W-1:0]; pb_wdata = sat_b; pb_raddr = idx_r[PIDX_W-1:0];
    bs_we = 1'b0; bs_waddr = idx_r; bs_wdata = '0; bs_raddr = idx_r;
    fp_we = 1'b0; fp_waddr = bkt_r; fp_wdata = fp_rdata + CNT_W'(1); fp_raddr = pb_rdata;
    se_we = 1'b0; se_waddr = fp_rdata[PIDX_W-1:0]; se_wdata = idx_r[PIDX_W-1:0];
    se_raddr = req_r.read_slot[PIDX_W-1:0];
    unique case (state_r)
      S_EXEC: begin
        if (req_r.req_type == REQ_ADD && !add_base[CNT_W-1]) begin
          pb_we    = 1'b1;
          pb_waddr = add_base[PIDX_W-1:0];
          pb_wdata = new_bucket;
        end
        bs_raddr = req_r.read_slot;
      end
      S_CLR: begin
        bs_we    = 1'b1;
        fp_we    = 1'b1;
        fp_waddr = '0;
        fp_wdata = '0;
      end
      S_CNT_B: begin
        pb_we    = 1'b1;
        bs_raddr = {1'b0, sat_b} + BS_AW'(1);
      end
      S_CNT_C: begin
        bs_we    = 1'b1;
        bs_waddr = {1'b0, bkt_r} + BS_AW'(1);
        bs_wdata = bs_rdata + CNT_W'(1);
      end
      S_PFX_B: begin
        bs_we    = 1'b1;
        bs_wdata = pfx_sum;
        fp_we    = idx_r < nb;
        fp_waddr = idx_r[BKT_W-1:0];
        fp_wdata = pfx_sum;
      end
      S_SC_C: begin
        se_we = 1'b1;
        fp_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      origin_x_r      <= '0;
      origin_y_r      <= '0;
      grid_width_r    <= DIM_W'(1);
      grid_height_r   <= DIM_W'(1);
      bucket_shift_r  <= SHIFT_W'(8);
      count_r         <= '0;
      closed_r        <= 1'b0;
      built_r         <= 1'b0;
      built_buckets_r <= CNT_W'(1);
      idx_r           <= '0;
      acc_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ORIGIN_X:     origin_x_r     <= cfg_wdata;
          CFG_ORIGIN_Y:     origin_y_r     <= cfg_wdata;
          CFG_GRID_WIDTH:   grid_width_r   <= cfg_wdata[DIM_W-1:0];
          CFG_GRID_HEIGHT:  grid_height_r  <= cfg_wdata[DIM_W-1:0];
          CFG_BUCKET_SHIFT: bucket_shift_r <= cfg_wdata[SHIFT_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            req_r   <= in_data;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_valid_r             <= 1'b1;
          out_data_r.result_value <= '0;
          out_data_r.status       <= ST_OK;
          state_r                 <= S_IDLE;
          case (req_r.req_type)
            REQ_ADD: begin
              closed_r <= 1'b0;
              if (add_base[CNT_W-1]) begin
                out_data_r.status <= ST_OVERFLOW;
                count_r           <= add_base;
              end else begin
                out_data_r.result_value <= VAL_W'(new_bucket);
                count_r                 <= add_base + CNT_W'(1);
              end
              if (req_r.last_point) begin
                idx_r   <= '0;
                state_r <= S_CLR;
              end
            end
            REQ_READ_ENTRY: begin
              if (closed_r && req_r.read_slot < count_r) begin
                out_valid_r <= 1'b0;
                state_r     <= S_RD;
              end else begin
                out_data_r.status <= ST_RANGE;
              end
            end
            REQ_READ_START: begin
              if (req_r.read_slot > built_buckets_r) begin
                out_data_r.status <= ST_RANGE;
              end else if (built_r) begin
                out_valid_r <= 1'b0;
                state_r     <= S_RD;
              end
            end
            default: begin
            end
          endcase
        end
        S_RD: begin
          out_valid_r             <= 1'b1;
          out_data_r.status       <= ST_OK;
          out_data_r.result_value <= (req_r.req_type == REQ_READ_ENTRY) ?
                                     VAL_W'(se_rdata) : bs_rdata;
          state_r                 <= S_IDLE;
        end
        S_CLR: begin
          if (idx_r == nb) begin
            idx_r   <= '0;
            state_r <= S_CNT_A;
          end else begin
            idx_r <= idx_r + CNT_W'(1);
          end
        end
        S_CNT_A: state_r <= S_CNT_B;
        S_CNT_B: begin
          bkt_r   <= sat_b;
          state_r <= S_CNT_C;
        end
        S_CNT_C: begin
          if (idx_r + CNT_W'(1) == count_r) begin
            idx_r   <= CNT_W'(1);
            acc_r   <= '0;
            state_r <= S_PFX_A;
          end else begin
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= S_CNT_A;
          end
        end
        S_PFX_A: state_r <= S_PFX_B;
        S_PFX_B: begin
          acc_r <= pfx_sum;
          if (idx_r == nb) begin
            idx_r   <= '0;
            state_r <= S_SC_A;
          end else begin
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= S_PFX_A;
          end
        end
        S_SC_A: state_r <= S_SC_B;
        S_SC_B: begin
          bkt_r   <= pb_rdata;
          state_r <= S_SC_C;
        end
        S_SC_C: begin
          if (idx_r + CNT_W'(1) == count_r) begin
            closed_r        <= 1'b1;
            built_r         <= 1'b1;
            built_buckets_r <= nb;
            state_r         <= S_IDLE;
          end else begin
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= S_SC_A;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  gbcs_ram #(.WIDTH(BKT_W), .DEPTH(MAX_POINTS)) u_point_bucket (
    .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
    .raddr(pb_raddr), .rdata(pb_rdata)
  );

  gbcs_ram #(.WIDTH(CNT_W), .DEPTH(BS_DEPTH)) u_bucket_start (
    .clk(clk), .we(bs_we), .waddr(bs_waddr), .wdata(bs_wdata),
    .raddr(bs_raddr), .rdata(bs_rdata)
  );

  gbcs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BUCKETS)) u_fill_pointer (
    .clk(clk), .we(fp_we), .waddr(fp_waddr), .wdata(fp_wdata),
    .raddr(fp_raddr), .rdata(fp_rdata)
  );

  gbcs_ram #(.WIDTH(PIDX_W), .DEPTH(MAX_POINTS)) u_sorted_entry (
    .clk(clk), .we(se_we), .waddr(se_waddr), .wdata(se_wdata),
    .raddr(se_raddr), .rdata(se_rdata)
  );

  `GBCS_ASSERT_NOW(a_ready_no_result, clk, rst_n, in_ready, !out_valid_r, "ready while result held")
  `GBCS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_POINTS), "count overflow")
  `GBCS_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_acc, state_r == S_EXEC, "accept not executed")

endmodule

>>> rtl/core/gbcs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module gbcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the grid bucket counting sort, with its own predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gbcs_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 1400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_wdata = '0;

  grid_bucket_counting_sort dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  int grid_ox, grid_oy, grid_w, grid_h, grid_shift;
  int pt_bucket[MAX_POINTS];
  int bkt_start[MAX_BUCKETS + 1];
  int bkt_fill[MAX_BUCKETS];
  int sorted_idx[MAX_POINTS];
  int pt_count, built_nb, rebuild_cycles;
  bit set_closed;

  out_t awaited_results[$];
  int errors = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int items_sent = 0;
  longint cycles = 0;

  typedef struct {
    in_t d;
    bit typed;
    out_t e;
  } stim_row_t;
  stim_row_t stim_rows[$];

  function automatic int clamp_dim(int d);
    if (d == 0) return 1;
    if (d > 64) return 64;
    return d;
  endfunction

  function automatic int axis_bucket(int off, int cnt);
    int b;
    if (off <= 0) return 0;
    b = off >> grid_shift;
    return (b >= cnt - 1) ? cnt - 1 : b;
  endfunction

  function automatic void rebuild_order();
    int nb, b;
    nb = clamp_dim(grid_w) * clamp_dim(grid_h);
    if (nb > MAX_BUCKETS) nb = MAX_BUCKETS;
    for (int i = 0; i <= MAX_BUCKETS; i++) bkt_start[i] = 0;
    for (int i = 0; i < pt_count; i++) begin
      b = pt_bucket[i];
      if (b >= nb) b = nb - 1;
      pt_bucket[i] = b;
      bkt_start[b + 1]++;
    end
    for (int i = 1; i <= nb; i++) bkt_start[i] += bkt_start[i - 1];
    for (int i = 0; i < nb; i++) bkt_fill[i] = bkt_start[i];
    for (int i = 0; i < pt_count; i++) begin
      b = pt_bucket[i];
      sorted_idx[bkt_fill[b] % MAX_POINTS] = i;
      bkt_fill[b]++;
    end
    built_nb = nb;
    set_closed = 1'b1;
    rebuild_cycles = 3 * nb + 6 * pt_count + 20;
  endfunction

  function automatic out_t sort_outcome(in_t d);
    out_t r;
    int w, h, b, slot;
    r = '0;
    slot = d.read_slot;
    case (d.req_type)
      REQ_ADD: begin
        if (set_closed) begin
          pt_count = 0;
          set_closed = 1'b0;
        end
        if (pt_count >= MAX_POINTS) begin
          r.status = ST_OVERFLOW;
        end else begin
          w = clamp_dim(grid_w);
          h = clamp_dim(grid_h);
          b = axis_bucket(int'(d.point_y) - grid_oy, h) * w
              + axis_bucket(int'(d.point_x) - grid_ox, w);
          if (b >= MAX_BUCKETS) b = MAX_BUCKETS - 1;
          pt_bucket[pt_count] = b;
          pt_count++;
          r.result_value = VAL_W'(b);
        end
        if (d.last_point) rebuild_order();
      end
      REQ_READ_ENTRY: begin
        if (set_closed && slot < pt_count) r.result_value = VAL_W'(sorted_idx[slot]);
        else r.status = ST_RANGE;
      end
      REQ_READ_START: begin
        if (slot <= built_nb) r.result_value = VAL_W'(bkt_start[slot]);
        else r.status = ST_RANGE;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_t exp_r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else if (rst_n) begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", out_data);
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_data.result_value !== exp_r.result_value
              || out_data.status !== exp_r.status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                       exp_r.result_value, exp_r.status,
                       out_data.result_value, out_data.status);
          end
        end
      end
    end
  end

  task automatic send_item(in_t d, bit typed = 1'b0, out_t e = '0);
    out_t p;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    p = sort_outcome(d);
    awaited_results.push_back(typed ? e : p);
    in_valid <= 1'b1;
    in_data <= d;
    items_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (rebuild_cycles) @(posedge clk);
  endtask

  task automatic configure(int ox, int oy, int w, int h, int sh);
    logic [COORD_W-1:0] vals[5];
    logic [CFG_IDX_W-1:0] idx[5];
    settle();
    vals = '{COORD_W'(ox), COORD_W'(oy), COORD_W'(w), COORD_W'(h), COORD_W'(sh)};
    idx = '{CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_GRID_WIDTH, CFG_GRID_HEIGHT, CFG_BUCKET_SHIFT};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    grid_ox = int'(signed'(COORD_W'(ox)));
    grid_oy = int'(signed'(COORD_W'(oy)));
    grid_w = w & 8'h7F;
    grid_h = h & 8'h7F;
    grid_shift = sh & 5'h1F;
  endtask

  function automatic in_t make_item(logic [1:0] rq, int x, int y, bit last, int slot);
    in_t d;
    d.req_type = rq;
    d.point_x = COORD_W'(x);
    d.point_y = COORD_W'(y);
    d.last_point = last;
    d.read_slot = VAL_W'(slot);
    return d;
  endfunction

  function automatic void add_row(logic [1:0] rq, int x, int y, bit last, int slot,
                                  bit typed = 1'b0, int val = 0, logic [1:0] st = ST_OK);
    stim_row_t r;
    r.d = make_item(rq, x, y, last, slot);
    r.typed = typed;
    r.e.result_value = VAL_W'(val);
    r.e.status = st;
    stim_rows.push_back(r);
  endfunction

  function automatic int rand_coord(int o, int dim);
    longint span, r;
    if ($urandom_range(9) < 3) return int'($urandom);
    span = longint'(clamp_dim(dim) + 1) << grid_shift;
    if (span > 64'h7FFF_FFFF) return int'($urandom);
    r = longint'($urandom_range(0, int'(span))) - (longint'(1) << grid_shift);
    return int'(o + r);
  endfunction

  function automatic int rand_dim();
    int k;
    if ($urandom_range(99) < 85) return $urandom_range(1, 8);
    k = $urandom_range(3);
    return (k == 0) ? 0 : (k == 1) ? 64 : (k == 2) ? 127 : $urandom_range(0, 127);
  endfunction

  task automatic random_config();
    int ox, oy;
    ox = ($urandom_range(99) < 80) ? int'($urandom_range(0, 4000)) - 2000 : int'($urandom);
    oy = ($urandom_range(99) < 80) ? int'($urandom_range(0, 4000)) - 2000 : int'($urandom);
    configure(ox, oy, rand_dim(), rand_dim(),
              ($urandom_range(99) < 80) ? $urandom_range(0, 12) : $urandom_range(0, 31));
  endtask

  task automatic random_set();
    int n, reads, k;
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) random_config();
      send_item(make_item(REQ_ADD, rand_coord(grid_ox, grid_w), rand_coord(grid_oy, grid_h),
                          (i == n - 1) && ($urandom_range(99) < 92), $urandom));
    end
    reads = $urandom_range(2, 12);
    for (int i = 0; i < reads; i++) begin
      k = $urandom_range(99);
      if (k < 45)
        send_item(make_item(REQ_READ_ENTRY, $urandom, $urandom, $urandom_range(1),
                            $urandom_range(0, pt_count + 1)));
      else if (k < 85)
        send_item(make_item(REQ_READ_START, $urandom, $urandom, $urandom_range(1),
                            $urandom_range(0, built_nb + 1)));
      else
        send_item(make_item(2'($urandom_range(1, 3)), $urandom, $urandom,
                            $urandom_range(1), $urandom));
    end
  endtask

  initial begin
    grid_ox = 0; grid_oy = 0; grid_w = 1; grid_h = 1; grid_shift = 8;
    pt_count = 0; set_closed = 1'b0; built_nb = 1; rebuild_cycles = 20;
    for (int i = 0; i <= MAX_BUCKETS; i++) bkt_start[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(REQ_READ_START, 0, 0, 0, 0, 1, 0, ST_OK);
    add_row(REQ_READ_START, 0, 0, 0, 1, 1, 0, ST_OK);
    add_row(REQ_READ_START, 0, 0, 0, 2, 1, 0, ST_RANGE);
    add_row(REQ_READ_ENTRY, 0, 0, 0, 0, 1, 0, ST_RANGE);
    add_row(2'd3, -1, -1, 1, 8191, 1, 0, ST_OK);
    add_row(REQ_ADD, 8388607, 8388607, 0, 8191, 1, 0, ST_OK);
    add_row(REQ_ADD, -8388608, -8388608, 1, 0, 1, 0, ST_OK);
    add_row(REQ_READ_ENTRY, 0, 0, 0, 0, 1, 0, ST_OK);
    add_row(REQ_READ_ENTRY, 0, 0, 0, 1, 1, 1, ST_OK);
    add_row(REQ_READ_ENTRY, 0, 0, 0, 2, 1, 0, ST_RANGE);
    add_row(REQ_READ_START, 0, 0, 0, 1, 1, 2, ST_OK);
    add_row(REQ_READ_START, 0, 0, 0, 8191, 1, 0, ST_RANGE);
    foreach (stim_rows[i]) send_item(stim_rows[i].d, stim_rows[i].typed, stim_rows[i].e);

    stim_rows.delete();
    configure(-5, -5, 4, 3, 0);
    add_row(REQ_ADD, -6, -6, 0, 0);
    add_row(REQ_ADD, 8388607, 8388607, 0, 0);
    add_row(REQ_ADD, -4, 0, 0, 0);
    add_row(REQ_ADD, -3, -4, 1, 0);
    add_row(REQ_READ_ENTRY, 0, 0, 0, 3);
    add_row(REQ_READ_START, 0, 0, 0, 12);
    add_row(REQ_READ_START, 0, 0, 0, 13);
    add_row(REQ_ADD, 100, 100, 1, 0);
    add_row(REQ_READ_ENTRY, 0, 0, 0, 1);
    foreach (stim_rows[i]) send_item(stim_rows[i].d);
    configure(8388607, -8388608, 0, 127, 31);
    send_item(make_item(REQ_ADD, -8388608, 8388607, 1, 0));

    while (items_sent < RANDOM_ITEMS + 25) begin
      if (items_sent < 490) begin
        sender_idle_pct = 32; receiver_stall_pct = 45;
      end else if (items_sent < 960) begin
        sender_idle_pct = 45; receiver_stall_pct = 32;
      end else begin
        sender_idle_pct = 0; receiver_stall_pct = 0;
      end
      if ($urandom_range(99) < 30) random_config();
      random_set();
    end

    settle();
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
